// ===== design/uvsg_pkg.sv =====
package uvsg_pkg;

   localparam int IDX_W   = 11;
   localparam int RAD_W   = 16;
   localparam int POS_W   = 17;
   localparam int Q15_W   = 16;
   localparam int TEX_W   = 17;
   localparam int NUM_W   = 28;
   localparam int ANG_W   = 34;
   localparam int STEPS   = 24;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;
   localparam int MAX_DIVS_DEF = 1024;

   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic signed [ANG_W-1:0] GAIN_Q30 = 34'sd652032874;

   localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
   localparam logic [IDX_W-1:0] RINGS_RST  = 11'd16;
   localparam logic [IDX_W-1:0] SECTORS_RST = 11'd32;

   localparam logic [1:0] REG_RADIUS  = 2'd0;
   localparam logic [1:0] REG_RINGS   = 2'd1;
   localparam logic [1:0] REG_SECTORS = 2'd2;

   typedef struct packed {
      logic [RAD_W-1:0] radius;
      logic [IDX_W-1:0] rings;
      logic [IDX_W-1:0] sectors;
   } cfg_type;

   function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         0:  v = 34'sh03243F6A8;
         1:  v = 34'sh01DAC6705;
         2:  v = 34'sh00FADBAFC;
         3:  v = 34'sh007F56EA6;
         4:  v = 34'sh003FEAB76;
         5:  v = 34'sh001FFD55B;
         6:  v = 34'sh000FFFAAA;
         7:  v = 34'sh0007FFF55;
         8:  v = 34'sh0003FFFEA;
         9:  v = 34'sh0001FFFFD;
         10: v = 34'sh0000FFFFF;
         11: v = 34'sh00007FFFF;
         12: v = 34'sh00003FFFF;
         13: v = 34'sh00001FFFF;
         14: v = 34'sh00000FFFF;
         15: v = 34'sh000007FFF;
         16: v = 34'sh000003FFF;
         17: v = 34'sh000001FFF;
         18: v = 34'sh000000FFF;
         19: v = 34'sh0000007FF;
         20: v = 34'sh0000003FF;
         21: v = 34'sh0000001FF;
         22: v = 34'sh0000000FF;
         23: v = 34'sh00000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

   // q30 magnitude to q15, ties up, clipped to 0..32767
   function automatic logic [Q15_W-2:0] to_q15(input logic signed [ANG_W-1:0] v);
      logic signed [ANG_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else begin
         r = (v + 34'sd16384) >>> 15;
      end
      return (r > 34'sd32767) ? 15'h7FFF : r[Q15_W-2:0];
   endfunction

   // divide by 2^15, ties away from zero
   function automatic logic signed [39:0] rnd15(input logic signed [39:0] v);
      logic [39:0] mag;
      logic [39:0] r;
      mag = (v < 0) ? 40'(-v) : 40'(v);
      r = (mag + 40'd16384) >> 15;
      return (v < 0) ? -$signed(r) : $signed(r);
   endfunction

endpackage

// ===== design/uv_sphere_vertex_generator_top.sv =====
// throughput: one item per cycle while the output is not held, set by the fully pipelined
// dividers and cordic units
// a 4-entry input queue keeps taking items while the pipeline holds for a full output
// reset: synchronous active high; clears queues and valid bits, registers return to
// radius 256, 16 rings and 32 full sectors
module uv_sphere_vertex_generator_top #(
   parameter int MAX_DIVS = uvsg_pkg::MAX_DIVS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [uvsg_pkg::IDX_W-1:0]         req_ring_index,
   input  logic [uvsg_pkg::IDX_W-1:0]         req_sector_index,
   output logic                               empty,
   input  logic                               pop,
   output logic signed [uvsg_pkg::POS_W-1:0]  rsp_pos_x,
   output logic signed [uvsg_pkg::POS_W-1:0]  rsp_pos_y,
   output logic signed [uvsg_pkg::POS_W-1:0]  rsp_pos_z,
   output logic signed [uvsg_pkg::Q15_W-1:0]  rsp_norm_x,
   output logic signed [uvsg_pkg::Q15_W-1:0]  rsp_norm_y,
   output logic signed [uvsg_pkg::Q15_W-1:0]  rsp_norm_z,
   output logic signed [uvsg_pkg::Q15_W-1:0]  rsp_tan_x,
   output logic signed [uvsg_pkg::Q15_W-1:0]  rsp_tan_y,
   output logic [uvsg_pkg::TEX_W-1:0]         rsp_tex_u,
   output logic [uvsg_pkg::TEX_W-1:0]         rsp_tex_v,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [uvsg_pkg::ADDR_W-1:0]        paddr,
   input  logic [uvsg_pkg::DATA_W-1:0]        pwdata,
   output logic [uvsg_pkg::DATA_W-1:0]        prdata,
   output logic                               pready
);
   import uvsg_pkg::*;

   cfg_type          cfg;
   logic             q_valid, q_pop;
   logic [IDX_W-1:0] q_ring, q_sector;

   uvsg_csr #(.MAX_DIVS(MAX_DIVS)) u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
   );

   uvsg_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .ring_index(req_ring_index), .sector_index(req_sector_index), .cfg(cfg),
      .q_pop(q_pop), .q_valid(q_valid), .q_ring(q_ring), .q_sector(q_sector)
   );

   uvsg_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .q_valid(q_valid), .q_ring(q_ring),
      .q_sector(q_sector), .q_pop(q_pop), .pop(pop), .empty(empty),
      .pos_x(rsp_pos_x), .pos_y(rsp_pos_y), .pos_z(rsp_pos_z),
      .norm_x(rsp_norm_x), .norm_y(rsp_norm_y), .norm_z(rsp_norm_z),
      .tan_x(rsp_tan_x), .tan_y(rsp_tan_y), .tex_u(rsp_tex_u), .tex_v(rsp_tex_v)
   );

endmodule

// ===== design/uvsg_csr.sv =====
module uvsg_csr #(
   parameter int MAX_DIVS = uvsg_pkg::MAX_DIVS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [uvsg_pkg::ADDR_W-1:0]  paddr,
   input  logic [uvsg_pkg::DATA_W-1:0]  pwdata,
   output logic [uvsg_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output uvsg_pkg::cfg_type            cfg
);
   import uvsg_pkg::*;

   logic [RAD_W-1:0] radius_ff;
   logic [IDX_W-1:0] rings_ff;
   logic [IDX_W-1:0] sectors_ff;
   logic [IDX_W:0]   half_s;
   logic             wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= RADIUS_RST;
         rings_ff   <= RINGS_RST;
         sectors_ff <= SECTORS_RST;
      end else if (wr) begin
         unique case (paddr[3:2])
            REG_RADIUS:  radius_ff  <= pwdata[RAD_W-1:0];
            REG_RINGS:   rings_ff   <= pwdata[IDX_W-1:0];
            REG_SECTORS: sectors_ff <= pwdata[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_RADIUS:  prdata = DATA_W'(radius_ff);
         REG_RINGS:   prdata = DATA_W'(rings_ff);
         REG_SECTORS: prdata = DATA_W'(sectors_ff);
         default:     prdata = '0;
      endcase
   end

   assign half_s = ((IDX_W+1)'(sectors_ff) + 12'd1) >> 1;

   always_comb begin
      cfg.radius = radius_ff;
      if (rings_ff == '0) begin
         cfg.rings = IDX_W'(1);
      end else if (32'(rings_ff) > MAX_DIVS) begin
         cfg.rings = IDX_W'(MAX_DIVS);
      end else begin
         cfg.rings = rings_ff;
      end
      if (half_s == '0) begin
         cfg.sectors = IDX_W'(1);
      end else if (32'(half_s) > MAX_DIVS) begin
         cfg.sectors = IDX_W'(MAX_DIVS);
      end else begin
         cfg.sectors = half_s[IDX_W-1:0];
      end
   end

endmodule

// ===== design/uvsg_front.sv =====
module uvsg_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [uvsg_pkg::IDX_W-1:0]  ring_index,
   input  logic [uvsg_pkg::IDX_W-1:0]  sector_index,
   input  uvsg_pkg::cfg_type           cfg,
   input  logic                        q_pop,
   output logic                        q_valid,
   output logic [uvsg_pkg::IDX_W-1:0]  q_ring,
   output logic [uvsg_pkg::IDX_W-1:0]  q_sector
);
   import uvsg_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   logic [IDX_W-1:0] ring_ff   [DEPTH];
   logic [IDX_W-1:0] sector_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic             do_push, do_pop;
   logic [IDX_W-1:0] ring_cl, sector_cl;

   assign full    = (count_ff == (PTR_W+1)'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = q_pop && q_valid;

   // clamp indices to the active counts on the way in
   assign ring_cl   = (ring_index > cfg.rings) ? cfg.rings : ring_index;
   assign sector_cl = (sector_index > cfg.sectors) ? cfg.sectors : sector_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ring_ff[wr_ptr_ff]   <= ring_cl;
         sector_ff[wr_ptr_ff] <= sector_cl;
      end
   end

   assign q_ring   = ring_ff[rd_ptr_ff];
   assign q_sector = sector_ff[rd_ptr_ff];

endmodule

// ===== design/uvsg_div.sv =====
module uvsg_div (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [uvsg_pkg::IDX_W-1:0]  k,
   input  logic [uvsg_pkg::IDX_W-1:0]  n,
   output logic [uvsg_pkg::TEX_W-1:0]  p
);
   import uvsg_pkg::*;

   // one quotient bit per stage, restoring
   localparam int QB = TEX_W;

   logic [NUM_W-1:0] rem_ff [QB];
   logic [TEX_W-1:0] q_ff   [QB];
   logic [IDX_W-1:0] n_ff   [QB];

   genvar s;
   for (s = 0; s < QB; s++) begin : g_stage
      logic [NUM_W-1:0] rem_src, sub;
      logic [TEX_W-1:0] q_src;
      logic [IDX_W-1:0] n_src;
      if (s == 0) begin : g_first
         assign rem_src = NUM_W'({k, 16'h0000}) + NUM_W'(n >> 1);
         assign q_src   = '0;
         assign n_src   = n;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign q_src   = q_ff[s-1];
         assign n_src   = n_ff[s-1];
      end
      assign sub = NUM_W'(n_src) << (QB-1-s);
      always_ff @(posedge clock) begin
         if (adv) begin
            n_ff[s] <= n_src;
            if (rem_src >= sub) begin
               rem_ff[s] <= rem_src - sub;
               q_ff[s]   <= q_src | (TEX_W'(1) << (QB-1-s));
            end else begin
               rem_ff[s] <= rem_src;
               q_ff[s]   <= q_src;
            end
         end
      end
   end

   assign p = q_ff[QB-1];

endmodule

// ===== design/uvsg_cordic.sv =====
module uvsg_cordic (
   input  logic                               clock,
   input  logic                               adv,
   input  logic signed [uvsg_pkg::ANG_W-1:0]  ang,
   output logic signed [uvsg_pkg::ANG_W-1:0]  cos_q30,
   output logic signed [uvsg_pkg::ANG_W-1:0]  sin_q30
);
   import uvsg_pkg::*;

   logic signed [ANG_W-1:0] x_ff [STEPS];
   logic signed [ANG_W-1:0] y_ff [STEPS];
   logic signed [ANG_W-1:0] z_ff [STEPS];

   genvar s;
   for (s = 0; s < STEPS; s++) begin : g_step
      logic signed [ANG_W-1:0] x_src, y_src, z_src, dx, dy;
      if (s == 0) begin : g_first
         assign x_src = GAIN_Q30;
         assign y_src = '0;
         assign z_src = ang;
      end else begin : g_next
         assign x_src = x_ff[s-1];
         assign y_src = y_ff[s-1];
         assign z_src = z_ff[s-1];
      end
      assign dx = y_src >>> s;
      assign dy = x_src >>> s;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (z_src >= 0) begin
               x_ff[s] <= x_src - dx;
               y_ff[s] <= y_src + dy;
               z_ff[s] <= z_src - atan_q30(s);
            end else begin
               x_ff[s] <= x_src + dx;
               y_ff[s] <= y_src - dy;
               z_ff[s] <= z_src + atan_q30(s);
            end
         end
      end
   end

   assign cos_q30 = x_ff[STEPS-1];
   assign sin_q30 = y_ff[STEPS-1];

endmodule

// ===== design/uvsg_back.sv =====
module uvsg_back (
   input  logic                               clock,
   input  logic                               reset,
   input  uvsg_pkg::cfg_type                  cfg,
   input  logic                               q_valid,
   input  logic [uvsg_pkg::IDX_W-1:0]         q_ring,
   input  logic [uvsg_pkg::IDX_W-1:0]         q_sector,
   output logic                               q_pop,
   input  logic                               pop,
   output logic                               empty,
   output logic signed [uvsg_pkg::POS_W-1:0]  pos_x,
   output logic signed [uvsg_pkg::POS_W-1:0]  pos_y,
   output logic signed [uvsg_pkg::POS_W-1:0]  pos_z,
   output logic signed [uvsg_pkg::Q15_W-1:0]  norm_x,
   output logic signed [uvsg_pkg::Q15_W-1:0]  norm_y,
   output logic signed [uvsg_pkg::Q15_W-1:0]  norm_z,
   output logic signed [uvsg_pkg::Q15_W-1:0]  tan_x,
   output logic signed [uvsg_pkg::Q15_W-1:0]  tan_y,
   output logic [uvsg_pkg::TEX_W-1:0]         tex_u,
   output logic [uvsg_pkg::TEX_W-1:0]         tex_v
);
   import uvsg_pkg::*;

   // issue, divider, angle, cordic, q15, normal, output
   localparam int LAT = 1 + TEX_W + 1 + STEPS + 1 + 1 + 1;

   typedef struct packed {
      logic [TEX_W-1:0] u;
      logic [TEX_W-1:0] v;
      logic             neg_s;
      logic             neg_t;
   } side_type;

   logic             vld_ff [LAT];
   logic             adv;
   logic [IDX_W-1:0] ki_ff, kj_ff;
   logic [TEX_W-1:0] pi_w, pj_w;
   logic [TEX_W-1:0] qi, qj;
   logic [47:0]      mi, mj;
   logic signed [ANG_W-1:0] ai_ff, aj_ff;
   side_type         side_ff [STEPS+1];
   logic signed [ANG_W-1:0] cs30, ss30, ct30, st30;
   logic signed [Q15_W-1:0] cs_ff, ss_ff, ct_ff, st_ff;
   logic [TEX_W-1:0] u3_ff, v3_ff, u4_ff, v4_ff;
   logic [Q15_W-2:0] cs_m, ct_m;
   logic signed [Q15_W-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [39:0] nx_w, ny_w, px_w, py_w, pz_w;
   logic signed [RAD_W:0] rad_s;

   assign adv   = !vld_ff[LAT-1] || pop;
   assign q_pop = adv && q_valid;
   assign empty = !vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LAT; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= q_valid;
         for (int s = 1; s < LAT; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ki_ff <= q_sector;
         kj_ff <= q_ring;
      end
   end

   uvsg_div u_div_s (.clock(clock), .adv(adv), .k(ki_ff), .n(cfg.sectors), .p(pi_w));
   uvsg_div u_div_r (.clock(clock), .adv(adv), .k(kj_ff), .n(cfg.rings), .p(pj_w));

   // fold into the first quadrant, phase to radians
   assign qi = (pi_w > 17'd32768) ? 17'd65536 - pi_w : pi_w;
   assign qj = (pj_w > 17'd32768) ? 17'd65536 - pj_w : pj_w;
   assign mi = 48'(qi[15:0]) * 48'(PI_Q30) + 48'd32768;
   assign mj = 48'(qj[15:0]) * 48'(PI_Q30) + 48'd32768;

   always_ff @(posedge clock) begin
      if (adv) begin
         ai_ff <= $signed(ANG_W'(mi >> 16));
         aj_ff <= $signed(ANG_W'(mj >> 16));
         side_ff[0].u     <= pi_w;
         side_ff[0].v     <= pj_w;
         side_ff[0].neg_s <= (pi_w > 17'd32768);
         side_ff[0].neg_t <= (pj_w > 17'd32768);
         for (int s = 1; s <= STEPS; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   uvsg_cordic u_cordic_s (.clock(clock), .adv(adv), .ang(ai_ff),
      .cos_q30(cs30), .sin_q30(ss30));
   uvsg_cordic u_cordic_r (.clock(clock), .adv(adv), .ang(aj_ff),
      .cos_q30(ct30), .sin_q30(st30));

   assign cs_m = to_q15(cs30);
   assign ct_m = to_q15(ct30);

   always_ff @(posedge clock) begin
      if (adv) begin
         cs_ff <= side_ff[STEPS].neg_s ? -$signed({1'b0, cs_m}) : $signed({1'b0, cs_m});
         ct_ff <= side_ff[STEPS].neg_t ? -$signed({1'b0, ct_m}) : $signed({1'b0, ct_m});
         ss_ff <= $signed({1'b0, to_q15(ss30)});
         st_ff <= $signed({1'b0, to_q15(st30)});
         u3_ff <= side_ff[STEPS].u;
         v3_ff <= side_ff[STEPS].v;
      end
   end

   assign nx_w = rnd15(40'(cs_ff * st_ff));
   assign ny_w = rnd15(40'(ss_ff * st_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff <= nx_w[Q15_W-1:0];
         ny_ff <= ny_w[Q15_W-1:0];
         nz_ff <= ct_ff;
         u4_ff <= u3_ff;
         v4_ff <= v3_ff;
      end
   end

   assign rad_s = $signed({1'b0, cfg.radius});
   assign px_w  = rnd15(40'(rad_s * nx_ff));
   assign py_w  = rnd15(40'(rad_s * ny_ff));
   assign pz_w  = rnd15(40'(rad_s * nz_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_x  <= px_w[POS_W-1:0];
         pos_y  <= py_w[POS_W-1:0];
         pos_z  <= pz_w[POS_W-1:0];
         norm_x <= nx_ff;
         norm_y <= ny_ff;
         norm_z <= nz_ff;
         tan_x  <= -ny_ff;
         tan_y  <= nx_ff;
         tex_u  <= u4_ff;
         tex_v  <= v4_ff;
      end
   end

endmodule

// ===== test/tb_uv_sphere_vertex_generator_top.sv =====
`timescale 1ns / 100ps

module tb_uv_sphere_vertex_generator_top;
   import uvsg_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
      logic [Q15_W-1:0] norm_x;
      logic [Q15_W-1:0] norm_y;
      logic [Q15_W-1:0] norm_z;
      logic [Q15_W-1:0] tan_x;
      logic [Q15_W-1:0] tan_y;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
   } vertex_type;

   class vertex_board;
      logic [RAD_W-1:0] radius;
      logic [IDX_W-1:0] rings;
      logic [IDX_W-1:0] sectors;
      vertex_type pending[$];
      int errors;

      function void restore();
         radius = RADIUS_RST;
         rings = RINGS_RST;
         sectors = SECTORS_RST;
      endfunction

      function longint fit_count(longint n);
         if (n == 0) return 1;
         return (n > MAX_DIVS_DEF) ? MAX_DIVS_DEF : n;
      endfunction

      function longint round15(longint v);
         longint mag;
         mag = (v < 0) ? -v : v;
         mag = (mag + 16384) >>> 15;
         return (v < 0) ? -mag : mag;
      endfunction

      function longint q30_mag(longint v);
         longint r;
         if (v < 0) v = 0;
         r = (v + 16384) >>> 15;
         return (r > 32767) ? 32767 : r;
      endfunction

      // sin and cos of k*pi/n in q1.15 by 24-step rotation cordic
      function void sincos(longint k, longint n, output longint sn, output longint cs);
         longint p, q, x, y, z, dx, dy;
         bit flip;
         p = (k * 65536 + n / 2) / n;
         q = p;
         flip = 0;
         if (p > 32768) begin
            q = 65536 - p;
            flip = 1;
         end
         z = (q * longint'(PI_Q30) + 32768) >>> 16;
         x = GAIN_Q30;
         y = 0;
         for (int s = 0; s < STEPS; s++) begin
            dx = y >>> s;
            dy = x >>> s;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= longint'(atan_q30_tab(s));
            end else begin
               x += dx;
               y -= dy;
               z += longint'(atan_q30_tab(s));
            end
         end
         cs = flip ? -q30_mag(x) : q30_mag(x);
         sn = q30_mag(y);
      endfunction

      function longint atan_q30_tab(int s);
         longint t[24] = '{'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76,
                           'h01FFD55B, 'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD,
                           'h000FFFFF, 'h0007FFFF, 'h0003FFFF, 'h0001FFFF, 'h0000FFFF,
                           'h00007FFF, 'h00003FFF, 'h00001FFF, 'h00000FFF, 'h000007FF,
                           'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};
         return t[s];
      endfunction

      function void note_item(logic [IDX_W-1:0] ring, logic [IDX_W-1:0] sector);
         longint nr, ns, j, i, ss, cs, st, ct, nx, ny;
         vertex_type v;
         nr = fit_count(rings);
         ns = fit_count((longint'(sectors) + 1) / 2);
         j = (ring > nr) ? nr : ring;
         i = (sector > ns) ? ns : sector;
         sincos(i, ns, ss, cs);
         sincos(j, nr, st, ct);
         nx = round15(cs * st);
         ny = round15(ss * st);
         v.pos_x = round15(radius * nx);
         v.pos_y = round15(radius * ny);
         v.pos_z = round15(radius * ct);
         v.norm_x = nx;
         v.norm_y = ny;
         v.norm_z = ct;
         v.tan_x = -ny;
         v.tan_y = nx;
         v.tex_u = (i * 65536 + ns / 2) / ns;
         v.tex_v = (j * 65536 + nr / 2) / nr;
         pending.push_back(v);
      endfunction

      function void check_item(vertex_type got);
         vertex_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected vertex %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("vertex mismatch: expected %h got %h", want, got);
         end
      endfunction
   endclass

   logic clock, reset, push, full, empty, pop;
   logic [IDX_W-1:0] req_ring_index, req_sector_index;
   logic signed [POS_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [Q15_W-1:0] rsp_norm_x, rsp_norm_y, rsp_norm_z, rsp_tan_x, rsp_tan_y;
   logic [TEX_W-1:0] rsp_tex_u, rsp_tex_v;
   logic psel, penable, pwrite, pready;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata, prdata;

   vertex_board board;
   bit calm;
   int sent;

   uv_sphere_vertex_generator_top uut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function bit idle_now();
      return !calm && ($urandom_range(99) < 28);
   endfunction

   task send_item(logic [IDX_W-1:0] ring, logic [IDX_W-1:0] sector);
      push <= 1;
      req_ring_index <= ring;
      req_sector_index <= sector;
      @(posedge clock);
      while (full) @(posedge clock);
      board.note_item(ring, sector);
      sent++;
      calm = (sent > 700 && sent < 950);
      if (idle_now()) begin
         push <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      case (idx)
         REG_RADIUS: board.radius = val[RAD_W-1:0];
         REG_RINGS: board.rings = val[IDX_W-1:0];
         REG_SECTORS: board.sectors = val[IDX_W-1:0];
         default: ;
      endcase
   endtask

   task drain();
      push <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // result side: pop at random, check at the accepting edge
   initial begin
      pop = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (pop && !empty)
            board.check_item('{rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_norm_x, rsp_norm_y,
                               rsp_norm_z, rsp_tan_x, rsp_tan_y, rsp_tex_u, rsp_tex_v});
         pop <= !idle_now();
      end
   end

   initial begin
      #(8 * 600000);
      $display("** uv_sphere_vertex_generator_top: FAILED **");
      $finish;
   end

   initial begin
      int radii[8] = '{256, 0, 65535, 1, 40000, 12345, 65535, 512};
      int ringset[8] = '{16, 0, 1024, 1, 2047, 7, 3, 1000};
      int sectset[8] = '{32, 0, 2047, 1, 2, 9, 1024, 63};
      int nr, ns;
      board = new();
      board.restore();
      reset = 1;
      push = 0;
      req_ring_index = 0;
      req_sector_index = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // corners under reset settings
      send_item(0, 0);
      send_item(16, 16);
      send_item(8, 8);
      send_item(4, 12);
      send_item(12, 4);
      send_item(2047, 2047);
      send_item(1024, 1024);
      send_item(17, 33);
      send_item(1, 31);
      send_item(15, 1);

      for (int ph = 0; ph < 8; ph++) begin
         drain();
         write_reg(REG_RADIUS, radii[ph]);
         write_reg(REG_RINGS, ringset[ph]);
         write_reg(REG_SECTORS, sectset[ph]);
         write_reg(2'd3, $urandom);
         nr = board.fit_count(ringset[ph]);
         ns = board.fit_count((sectset[ph] + 1) / 2);
         send_item(0, 0);
         send_item(nr, ns);
         send_item(nr / 2, ns / 2);
         for (int k = 0; k < 195; k++) begin
            if ($urandom_range(9) == 0)
               send_item($urandom_range(2047), $urandom_range(2047));
            else
               send_item($urandom_range(nr + 1), $urandom_range(ns + 1));
         end
      end
      drain();

      if (board.errors == 0 && board.pending.size() == 0)
         $display("** uv_sphere_vertex_generator_top: PASSED **");
      else
         $display("** uv_sphere_vertex_generator_top: FAILED **");
      $finish;
   end

endmodule
